### hw/rtl/assert_macros.svh
// assertion macros shared by the rle decoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
	else $error("implication check failed");
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
	else $error("next-cycle check failed");
`else
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

### hw/rtl/trd_pkg.sv
// types and constants of the tga rle pixel decoder
`default_nettype none
package trd_pkg;

	localparam int MAX_BYTES_PER_PIXEL = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd2;

	typedef struct packed {
		logic [2:0] bytes_per_pixel;
		logic [31:0] total_pixels;
	} cfg_t;

	typedef struct packed {
		logic [31:0] pixel_value;
		logic [7:0] repeat_count;
		logic last_of_image;
		logic overrun;
	} res_t;

	typedef struct packed {
		logic produce;
		res_t res;
	} dec_t;

endpackage
`default_nettype wire

### hw/rtl/trd_cfg.sv
// configuration registers and image pixel count
`default_nettype none
module trd_cfg (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [trd_pkg::CFG_DATA_W-1:0] cfg_data,
	output trd_pkg::cfg_t cfg
);
	import trd_pkg::*;

	logic [2:0] bpp_q;
	logic [15:0] width_q;
	logic [15:0] height_q;
	logic [31:0] total_q;
	logic [15:0] mul_w;
	logic [15:0] mul_h;
	logic [31:0] total_next;
	logic wr;

	assign cfg_ready = 1'b1;
	assign wr = cfg_valid && cfg_ready;

	// pixel count follows the register being written
	always_comb begin
		mul_w = (cfg_index == REG_IMAGE_WIDTH) ? cfg_data : width_q;
		mul_h = (cfg_index == REG_IMAGE_HEIGHT) ? cfg_data : height_q;
		if (mul_w == 16'd0 || mul_h == 16'd0) begin
			total_next = 32'd1;
		end else begin
			total_next = mul_w * mul_h;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bpp_q <= 3'd4;
			width_q <= 16'd1;
			height_q <= 16'd1;
			total_q <= 32'd1;
		end else if (wr) begin
			case (cfg_index)
				REG_BYTES_PER_PIXEL: begin
					bpp_q <= cfg_data[2:0];
				end
				REG_IMAGE_WIDTH: begin
					width_q <= cfg_data;
					total_q <= total_next;
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= cfg_data;
					total_q <= total_next;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.bytes_per_pixel = bpp_q;
	assign cfg.total_pixels = total_q;
endmodule
`default_nettype wire

### hw/rtl/trd_core.sv
// packet state and pixel assembly, one byte per cycle while fire is high
`default_nettype none
module trd_core (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic fire,
	input wire logic [7:0] data_byte,
	input wire trd_pkg::cfg_t cfg,
	output trd_pkg::dec_t dec
);
	import trd_pkg::*;

	logic awaiting_q;
	logic run_q;
	logic clipped_q;
	logic [7:0] pkt_left_q;
	logic [1:0] byte_pos_q;
	logic [31:0] acc_q;
	logic [31:0] img_left_q;

	logic [2:0] ebpp;
	logic [31:0] img_eff;
	logic [7:0] hdr_n;
	logic hdr_clip;
	logic [7:0] hdr_n_clip;
	logic [31:0] acc_new;
	logic complete;
	logic [7:0] cnt_raw;
	logic [7:0] cnt;
	logic [31:0] img_after;
	logic [7:0] pkt_after;
	logic last;

	always_comb begin
		ebpp = cfg.bytes_per_pixel;
		if (ebpp == 3'd0) begin
			ebpp = 3'd1;
		end
		if (ebpp > 3'(MAX_BYTES_PER_PIXEL)) begin
			ebpp = 3'(MAX_BYTES_PER_PIXEL);
		end

		// header path
		img_eff = (img_left_q == 32'd0) ? cfg.total_pixels : img_left_q;
		hdr_n = data_byte[7] ? (data_byte - 8'd127) : (data_byte + 8'd1);
		hdr_clip = {24'd0, hdr_n} > img_eff;
		hdr_n_clip = hdr_clip ? img_eff[7:0] : hdr_n;

		// pixel byte path
		acc_new = ((byte_pos_q == 2'd0) ? 32'd0 : acc_q)
			| ({24'd0, data_byte} << {byte_pos_q, 3'b000});
		complete = ({1'b0, byte_pos_q} + 3'd1) >= ebpp;
		cnt_raw = run_q ? pkt_left_q : 8'd1;
		if (cnt_raw == 8'd0) begin
			cnt_raw = 8'd1;
		end
		cnt = ({24'd0, cnt_raw} > img_left_q) ? img_left_q[7:0] : cnt_raw;
		img_after = img_left_q - {24'd0, cnt};
		pkt_after = (cnt <= pkt_left_q) ? (pkt_left_q - cnt) : 8'd0;
		last = img_after == 32'd0;

		dec.produce = !awaiting_q && complete;
		dec.res.pixel_value = acc_new;
		dec.res.repeat_count = cnt;
		dec.res.last_of_image = last;
		dec.res.overrun = clipped_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			run_q <= 1'b0;
			clipped_q <= 1'b0;
			pkt_left_q <= 8'd0;
			byte_pos_q <= 2'd0;
			acc_q <= 32'd0;
			img_left_q <= 32'd0;
		end else if (fire) begin
			if (awaiting_q) begin
				img_left_q <= img_eff;
				run_q <= data_byte[7];
				clipped_q <= hdr_clip;
				pkt_left_q <= hdr_n_clip;
				awaiting_q <= 1'b0;
				byte_pos_q <= 2'd0;
				acc_q <= 32'd0;
			end else begin
				acc_q <= acc_new;
				if (!complete) begin
					byte_pos_q <= byte_pos_q + 2'd1;
				end else begin
					byte_pos_q <= 2'd0;
					img_left_q <= img_after;
					pkt_left_q <= pkt_after;
					if (last || pkt_after == 8'd0) begin
						awaiting_q <= 1'b1;
						run_q <= 1'b0;
						pkt_left_q <= 8'd0;
						if (last) begin
							clipped_q <= 1'b0;
						end
					end
				end
			end
		end
	end
endmodule
`default_nettype wire

### hw/rtl/tga_rle_pixel_decoder.sv
// tga rle pixel decoder top level: input stage, decode core, result register
// a result reaches m_tdata through the input stage register, then the result register
// throughput: one byte per cycle; a stalled result register holds the input stage
// header beats give no result; pixel count loads from width*height at an image start
// arst_n clears all control state and restores register defaults 4, 1, 1
`default_nettype none
`include "assert_macros.svh"
module tga_rle_pixel_decoder (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	output logic s_tready,
	input wire logic [7:0] s_tdata, // data_byte[7:0]
	output logic m_tvalid,
	input wire logic m_tready,
	output logic [39:0] m_tdata, // pixel_value[31:0], repeat_count[39:32]
	output logic m_tlast,
	output logic m_tuser, // overrun
	input wire logic cfg_valid,
	output logic cfg_ready,
	input wire logic [trd_pkg::CFG_IDX_W-1:0] cfg_index,
	input wire logic [trd_pkg::CFG_DATA_W-1:0] cfg_data
);
	import trd_pkg::*;

	cfg_t cfg;
	dec_t dec;
	logic valid_s1;
	logic [7:0] data_s1;
	logic out_valid_q;
	res_t res_q;
	logic out_free;
	logic advance;

	trd_cfg u_cfg (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.cfg(cfg)
	);

	trd_core u_core (
		.clk(clk),
		.arst_n(arst_n),
		.fire(advance),
		.data_byte(data_s1),
		.cfg(cfg),
		.dec(dec)
	);

	assign out_free = !out_valid_q || m_tready;
	assign advance = valid_s1 && (!dec.produce || out_free);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && dec.produce) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && dec.produce) begin
			res_q <= dec.res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = {res_q.repeat_count, res_q.pixel_value};
	assign m_tlast = res_q.last_of_image;
	assign m_tuser = res_q.overrun;

	`ASSERT_IMPL(a_count_nonzero, clk, arst_n, m_tvalid, m_tdata[39:32] != 8'd0)
	`ASSERT_IMPL(a_empty_stage_ready, clk, arst_n, !valid_s1, s_tready)
	`ASSERT_NEXT(a_stall_holds_byte, clk, arst_n, valid_s1 && !advance,
		valid_s1 && $stable(data_s1))
endmodule
`default_nettype wire
